// File: hdl/dtpc_pkg.sv
// Shared constants, codes and interface types for the digit trie prefix
// conflict checker. No dependencies; every other file imports this package.
package dtpc_pkg;

  localparam int NODE_COUNT = 4096;
  localparam int RADIX      = 10;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int FREE_W     = IDX_W + 1;
  // Node row: RADIX child pointers, end mark in the top bit.
  localparam int ROW_W      = RADIX * IDX_W + 1;

  localparam logic [IDX_W-1:0]  ROOT_NODE  = IDX_W'(1);
  localparam logic [IDX_W-1:0]  NO_NODE    = '0;
  localparam logic [FREE_W-1:0] FIRST_FREE = FREE_W'(2);
  localparam logic [FREE_W-1:0] POOL_LIMIT = FREE_W'(NODE_COUNT);
  localparam logic [3:0]        DIGIT_MAX  = 4'd9;

  localparam logic KIND_DIGIT = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_EVAL,
    CMD_CHECK,
    CMD_ALLOC
  } dtpc_op_t;

  typedef struct packed {
    dtpc_op_t op;
    logic     load_out;
  } dtpc_cmd_t;

  typedef struct packed {
    logic go_check;
    logic go_alloc;
    logic out_free;
  } dtpc_status_t;

endpackage

// File: hdl/dtpc_ctrl.sv
// Controller for the digit trie checker: sequences each item through the
// datapath and decides when a result is loaded. Depends on dtpc_pkg.
module dtpc_ctrl import dtpc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_valid,
  input  logic         kind,
  input  dtpc_status_t status,
  output logic         s_ready,
  output dtpc_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ALLOC
  } state_t;

  state_t state, state_next;
  logic   pend, pend_next;
  logic   finish;
  logic   accept;

  assign s_ready = (state == ST_IDLE) && !pend;
  assign accept  = s_valid && s_ready;

  always_comb begin
    state_next   = state;
    pend_next    = pend;
    cmd.op       = CMD_NONE;
    cmd.load_out = 1'b0;
    finish       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (pend) begin
          // flush a result that found the output register busy
          if (status.out_free) begin
            cmd.load_out = 1'b1;
            pend_next    = 1'b0;
          end
        end else if (accept) begin
          if (kind == KIND_CLEAR) begin
            cmd.op = CMD_CLEAR;
            finish = 1'b1;
          end else begin
            cmd.op = CMD_EVAL;
            if (status.go_check) begin
              state_next = ST_CHECK;
            end else if (status.go_alloc) begin
              state_next = ST_ALLOC;
            end else begin
              finish = 1'b1;
            end
          end
        end
      end
      ST_CHECK: begin
        cmd.op     = CMD_CHECK;
        finish     = 1'b1;
        state_next = ST_IDLE;
      end
      ST_ALLOC: begin
        cmd.op     = CMD_ALLOC;
        finish     = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (finish) begin
      if (status.out_free) begin
        cmd.load_out = 1'b1;
      end else begin
        pend_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

endmodule

// File: hdl/dtpc_dp.sv
// Datapath for the digit trie checker: node row memory, walk registers,
// allocation pointer, sticky flags and the result register. Depends on dtpc_pkg.
module dtpc_dp import dtpc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  dtpc_cmd_t    cmd,
  input  logic [3:0]   digit_in,
  input  logic         last_in,
  input  logic         out_ready,
  output dtpc_status_t status,
  output logic         out_valid,
  output logic [1:0]   out_flags
);

  logic [ROW_W-1:0]  mem [NODE_COUNT];
  logic [ROW_W-1:0]  rd_row;

  logic [IDX_W-1:0]  cur_node, cur_node_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [ROW_W-1:0]  root_row, root_row_next;
  logic [FREE_W-1:0] next_free, next_free_next;
  logic              created, created_next;
  logic              conflict, conflict_next;
  logic              full, full_next;
  logic [IDX_W-1:0]  lat_child, lat_child_next;
  logic              lat_last, lat_last_next;

  logic [3:0]        d_sat;
  logic [IDX_W-1:0]  child;
  logic              detached;
  logic              child_zero;
  logic              pool_free;
  logic [ROW_W-1:0]  grown_row;
  logic [ROW_W-1:0]  end_bit;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [ROW_W-1:0]  mem_wdata;
  logic              mem_re;

  assign d_sat      = (digit_in > DIGIT_MAX) ? DIGIT_MAX : digit_in;
  assign child      = cur_row[d_sat*IDX_W +: IDX_W];
  assign detached   = (cur_node == NO_NODE);
  assign child_zero = (child == NO_NODE);
  assign pool_free  = (next_free < POOL_LIMIT);
  assign end_bit    = {1'b1, {(ROW_W-1){1'b0}}};

  assign status.go_check = !detached && !child_zero;
  assign status.go_alloc = !detached && child_zero && pool_free;
  assign status.out_free = !out_valid || out_ready;

  // parent row with the missing child pointed at the next free node
  always_comb begin
    grown_row[ROW_W-1] = cur_row[ROW_W-1];
    for (int i = 0; i < RADIX; i++) begin
      grown_row[i*IDX_W +: IDX_W] = (4'(i) == d_sat) ? next_free[IDX_W-1:0]
                                                     : cur_row[i*IDX_W +: IDX_W];
    end
  end

  always_comb begin
    cur_node_next  = cur_node;
    cur_row_next   = cur_row;
    root_row_next  = root_row;
    next_free_next = next_free;
    created_next   = created;
    conflict_next  = conflict;
    full_next      = full;
    lat_child_next = lat_child;
    lat_last_next  = lat_last;
    mem_we         = 1'b0;
    mem_waddr      = lat_child;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    case (cmd.op)
      CMD_CLEAR: begin
        cur_node_next  = ROOT_NODE;
        cur_row_next   = '0;
        root_row_next  = '0;
        next_free_next = FIRST_FREE;
        created_next   = 1'b0;
        conflict_next  = 1'b0;
        full_next      = 1'b0;
      end
      CMD_EVAL: begin
        lat_last_next  = last_in;
        lat_child_next = child;
        if (detached) begin
          created_next = 1'b1;
          if (last_in) begin
            cur_node_next = ROOT_NODE;
            cur_row_next  = root_row;
            created_next  = 1'b0;
          end
        end else if (!child_zero) begin
          mem_re = 1'b1;
        end else if (pool_free) begin
          mem_we         = 1'b1;
          mem_waddr      = cur_node;
          mem_wdata      = grown_row;
          cur_row_next   = grown_row;
          if (cur_node == ROOT_NODE) begin
            root_row_next = grown_row;
          end
          created_next   = 1'b1;
          next_free_next = next_free + FREE_W'(1);
          lat_child_next = next_free[IDX_W-1:0];
        end else begin
          // pool exhausted: drop off the trie until the number ends
          full_next    = 1'b1;
          created_next = 1'b1;
          if (last_in) begin
            cur_node_next = ROOT_NODE;
            cur_row_next  = root_row;
            created_next  = 1'b0;
          end else begin
            cur_node_next = NO_NODE;
          end
        end
      end
      CMD_CHECK: begin
        conflict_next = conflict | rd_row[ROW_W-1] | (lat_last & ~created);
        if (lat_last) begin
          mem_we        = 1'b1;
          mem_waddr     = lat_child;
          mem_wdata     = rd_row | end_bit;
          cur_node_next = ROOT_NODE;
          cur_row_next  = root_row;
          created_next  = 1'b0;
        end else begin
          cur_node_next = lat_child;
          cur_row_next  = rd_row;
        end
      end
      CMD_ALLOC: begin
        // zero the fresh node's row so stale contents never show through
        mem_we    = 1'b1;
        mem_waddr = lat_child;
        mem_wdata = lat_last ? end_bit : '0;
        if (lat_last) begin
          cur_node_next = ROOT_NODE;
          cur_row_next  = root_row;
          created_next  = 1'b0;
        end else begin
          cur_node_next = lat_child;
          cur_row_next  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row <= mem[child];
    end
  end

  always_ff @(posedge clk) begin
    lat_child <= lat_child_next;
    lat_last  <= lat_last_next;
    if (cmd.load_out) begin
      out_flags <= {full_next, conflict_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_node  <= ROOT_NODE;
      cur_row   <= '0;
      root_row  <= '0;
      next_free <= FIRST_FREE;
      created   <= 1'b0;
      conflict  <= 1'b0;
      full      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cur_node  <= cur_node_next;
      cur_row   <= cur_row_next;
      root_row  <= root_row_next;
      next_free <= next_free_next;
      created   <= created_next;
      conflict  <= conflict_next;
      full      <= full_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/digit_trie_prefix_conflict_top.sv
// Top level of the digit trie prefix conflict checker: stream ports,
// controller and datapath. Depends on dtpc_pkg, dtpc_ctrl and dtpc_dp.
//
// Numbers arrive one decimal digit per input transfer (tlast marks the final
// digit, tuser = 1 clears the list) and every input transfer yields exactly
// one output transfer carrying the sticky conflict and pool-full flags.
// A clear, a digit of a number that already ran out of nodes, or a digit
// that finds a missing child with the pool exhausted ends in the idle state.
// A digit whose child exists adds the check state: the child's row (its
// pointers and end mark) is read from the node memory, whose read data is
// registered, before the end mark can be checked. A digit that allocates a
// node adds the alloc state because the parent row update and the zeroing
// of the new row share the single write port. Each node's row is zeroed when
// it is allocated and the root row lives in a register, so neither reset nor
// a clear transfer needs a pass over memory. A result that finds the output
// register still occupied holds the input side until it can be loaded.
module digit_trie_prefix_conflict_top import dtpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [3:0] digit, [7:4] zero
  input  logic       s_tuser,   // [0] kind
  input  logic       s_tlast,   // last_digit
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] prefix_conflict, [1] table_full, [7:2] zero
);

  dtpc_cmd_t    cmd;
  dtpc_status_t status;
  logic [1:0]   out_flags;

  dtpc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .kind    (s_tuser),
    .status  (status),
    .s_ready (s_tready),
    .cmd     (cmd)
  );

  dtpc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .digit_in  (s_tdata[3:0]),
    .last_in   (s_tlast),
    .out_ready (m_tready),
    .status    (status),
    .out_valid (m_tvalid),
    .out_flags (out_flags)
  );

  assign m_tdata = {6'b0, out_flags};

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending output");

  a_check_follows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == KIND_DIGIT && status.go_check)
      |=> cmd.op == CMD_CHECK)
    else $error("existing child not checked after lookup");

  a_alloc_after_eval: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == CMD_ALLOC) |-> $past(cmd.op) == CMD_EVAL)
    else $error("row zeroing without preceding allocation");

endmodule
